>>> rtl/object_header_char_parser_top_defines.svh
// Assertion macros shared by the RTL of the object header character parser.
// Define ASSERT_OFF to compile all checks out.
`ifndef OBJECT_HEADER_CHAR_PARSER_TOP_DEFINES_SVH
`define OBJECT_HEADER_CHAR_PARSER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define OHCP_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("ohcp check failed");
// Next-cycle implication
`define OHCP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("ohcp check failed");
`else
`define OHCP_ASSERT_IMPLY(label, clk, rst_n, cond, expr)
`define OHCP_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

>>> rtl/ohcp_pkg.sv
`timescale 1ns / 1ps

package ohcp_pkg;

	// Parse position
	typedef enum logic [3:0] {
		POS_LEAD         = 4'd0,
		POS_TYPE         = 4'd1,
		POS_AFTER_TYPE   = 4'd2,
		POS_AFTER_COLONS = 4'd3,
		POS_SPACE        = 4'd4,
		POS_AFTER_SPACE  = 4'd5,
		POS_NAME         = 4'd6,
		POS_AFTER_NAME   = 4'd7,
		POS_BODY         = 4'd8,
		POS_END          = 4'd9,
		POS_FINISHED     = 4'd10
	} pos_t;

	// Part a character belongs to
	typedef enum logic [2:0] {
		TAG_SKIP  = 3'd0,
		TAG_TYPE  = 3'd1,
		TAG_SPACE = 3'd2,
		TAG_NAME  = 3'd3,
		TAG_BODY  = 3'd4
	} tag_t;

	// Grammar errors
	typedef enum logic [2:0] {
		ERR_NONE         = 3'd0,
		ERR_COLON_FIRST  = 3'd1,
		ERR_NO_COLON2    = 3'd2,
		ERR_EXTRA_COLON  = 3'd3,
		ERR_CLOSE_NAME   = 3'd4,
		ERR_EMPTY_BODY   = 3'd5,
		ERR_OPEN_BODY    = 3'd6
	} err_t;

	// Characters of the grammar
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Per-character result, without the character itself
	typedef struct packed {
		tag_t tag;
		logic name_done;
		err_t err;
		pos_t pos;
		logic done;
	} res_t;

endpackage

>>> rtl/ohcp_step.sv
`timescale 1ns / 1ps

module ohcp_step
	import ohcp_pkg::*;
(
	input  pos_t       pos,
	input  logic       failed,
	input  logic [7:0] char_code,
	input  logic       start_req,
	input  logic       last,
	output pos_t       pos_next,
	output logic       failed_next,
	output res_t       res
);

	pos_t pos_cur;
	logic fail_cur;
	logic ws_full;
	logic blank;
	logic sep;
	logic err_hit;

	// Character classes
	always_comb begin
		ws_full = char_code inside {CH_SPACE, CH_CR, CH_LF, CH_TAB};
		blank   = char_code inside {CH_SPACE, CH_TAB};
		sep     = char_code inside {CH_SPACE, CH_DOT, CH_TAB};
	end

	// Start clears the parser ahead of its own character
	assign pos_cur  = start_req ? POS_LEAD : pos;
	assign fail_cur = start_req ? 1'b0 : failed;

	// Transition for one character
	always_comb begin
		pos_next      = pos_cur;
		failed_next   = fail_cur;
		res.tag       = TAG_SKIP;
		res.name_done = 1'b0;
		res.err       = ERR_NONE;
		res.done      = 1'b0;
		err_hit       = 1'b0;
		if (!fail_cur) begin
			case (pos_cur)
				POS_LEAD: begin
					if (ws_full) begin
					end else if (char_code == CH_COLON) begin
						res.err = ERR_COLON_FIRST;
					end else begin
						pos_next = POS_TYPE;
						res.tag  = TAG_TYPE;
					end
				end
				POS_TYPE: begin
					if (blank) begin
					end else if (char_code == CH_COLON) begin
						pos_next = POS_AFTER_TYPE;
					end else begin
						res.tag = TAG_TYPE;
					end
				end
				POS_AFTER_TYPE: begin
					if (blank) begin
					end else if (char_code == CH_COLON) begin
						pos_next = POS_AFTER_COLONS;
					end else begin
						res.err = ERR_NO_COLON2;
					end
				end
				POS_AFTER_COLONS: begin
					if (blank) begin
					end else if (char_code == CH_COLON) begin
						res.err = ERR_EXTRA_COLON;
					end else begin
						pos_next = POS_SPACE;
						res.tag  = TAG_SPACE;
					end
				end
				POS_SPACE: begin
					if (sep) begin
						pos_next = POS_AFTER_SPACE;
					end else begin
						res.tag = TAG_SPACE;
					end
				end
				POS_AFTER_SPACE: begin
					if (!sep) begin
						pos_next = POS_NAME;
						res.tag  = TAG_NAME;
					end
				end
				POS_NAME: begin
					if (ws_full) begin
						pos_next      = POS_AFTER_NAME;
						res.name_done = 1'b1;
					end else if (char_code == CH_LBRACE) begin
						pos_next      = POS_BODY;
						res.name_done = 1'b1;
					end else if (char_code == CH_RBRACE) begin
						res.err = ERR_CLOSE_NAME;
					end else begin
						res.tag = TAG_NAME;
					end
				end
				POS_AFTER_NAME: begin
					if (ws_full) begin
					end else if (char_code == CH_LBRACE) begin
						pos_next = POS_BODY;
					end else if (char_code == CH_RBRACE) begin
						pos_next = POS_END;
						res.err  = ERR_EMPTY_BODY;
					end else begin
						pos_next = POS_BODY;
						res.tag  = TAG_BODY;
					end
				end
				POS_BODY: begin
					if (char_code == CH_RBRACE) begin
						pos_next = POS_END;
					end else if (char_code == CH_LBRACE) begin
						res.err = ERR_OPEN_BODY;
					end else begin
						res.tag = TAG_BODY;
					end
				end
				default: begin
				end
			endcase
			err_hit = (res.err != ERR_NONE);
			if (err_hit) begin
				failed_next = 1'b1;
			end else if (last) begin
				pos_next = POS_FINISHED;
				res.done = 1'b1;
			end
		end
		res.pos = pos_next;
	end

endmodule

>>> rtl/ohcp_out_reg.sv
`timescale 1ns / 1ps

module ohcp_out_reg
	import ohcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  res_t       res,
	input  logic [7:0] char_code,
	input  logic       out_ready,
	output logic       free,
	output logic       out_valid,
	output res_t       res_out,
	output logic [7:0] char_out
);

	logic       valid_s1;
	res_t       res_s1;
	logic [7:0] char_s1;

	// Register can take a new transaction when empty or being drained
	assign free = !valid_s1 || out_ready;

	// Valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (free) begin
			valid_s1 <= load;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load && free) begin
			res_s1  <= res;
			char_s1 <= char_code;
		end
	end

	assign out_valid = valid_s1;
	assign res_out   = res_s1;
	assign char_out  = char_s1;

endmodule

>>> rtl/object_header_char_parser_top.sv
`timescale 1ns / 1ps
// Object header character parser.
// Input channel (in_valid/in_ready) takes one character of a definition
// "type :: space.name { body }" per transaction, with start_req (reset the
// parse before this character) and last (finish the string after it).
// Output channel (out_valid/out_ready) returns one result per character:
// part tag, the character, name-complete flag, error code, parse position
// after the character and a successful-finish flag.
// The result is registered and presented in the cycle after the input is accepted.
// Throughput: one character per cycle while the receiver does not stall; the
// parse state update and the character classification are combinational, and
// the only storage on the path is the result register.
// When the receiver stalls, the result register holds its transaction and
// in_ready drops; in_ready is high whenever the result register is empty
// or is being drained in the same cycle.
// Reset clears the parse position to the leading-blank state, clears the
// error latch and empties the result register.
`include "object_header_char_parser_top_defines.svh"

module object_header_char_parser_top
	import ohcp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       start_req,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] part_tag,
	output logic [7:0] char_out,
	output logic       name_done,
	output logic [2:0] error_code,
	output logic [3:0] parse_state,
	output logic       done_res
);

	pos_t pos_q;
	logic failed_q;
	pos_t pos_next;
	logic failed_next;
	res_t res_new;
	res_t res_out;
	logic free;
	logic in_fire;

	assign in_ready = free;
	assign in_fire  = in_valid && free;

	// Next-state logic for one character
	ohcp_step u_step (
		.pos         (pos_q),
		.failed      (failed_q),
		.char_code   (char_code),
		.start_req   (start_req),
		.last        (last),
		.pos_next    (pos_next),
		.failed_next (failed_next),
		.res         (res_new)
	);

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_LEAD;
			failed_q <= 1'b0;
		end else if (in_fire) begin
			pos_q    <= pos_next;
			failed_q <= failed_next;
		end
	end

	// Result register
	ohcp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_valid),
		.res       (res_new),
		.char_code (char_code),
		.out_ready (out_ready),
		.free      (free),
		.out_valid (out_valid),
		.res_out   (res_out),
		.char_out  (char_out)
	);

	assign part_tag    = res_out.tag;
	assign name_done   = res_out.name_done;
	assign error_code  = res_out.err;
	assign parse_state = res_out.pos;
	assign done_res    = res_out.done;

	// Checks
	`OHCP_ASSERT_NEXT(a_fire_gives_result, clk, arst_n, in_fire, out_valid)
	`OHCP_ASSERT_IMPLY(a_done_is_finished, clk, arst_n, out_valid && done_res,
		parse_state == POS_FINISHED && error_code == ERR_NONE)
	`OHCP_ASSERT_IMPLY(a_error_skips, clk, arst_n, out_valid && error_code != ERR_NONE,
		part_tag == TAG_SKIP && !name_done && !done_res)
	`OHCP_ASSERT_IMPLY(a_name_done_pos, clk, arst_n, out_valid && name_done,
		parse_state == POS_AFTER_NAME || parse_state == POS_BODY ||
		parse_state == POS_FINISHED)
	`OHCP_ASSERT_NEXT(a_failed_holds, clk, arst_n, in_fire && failed_q && !start_req,
		failed_q && pos_q == $past(pos_q))

endmodule
